// File: sv/ael_pkg.sv
`default_nettype none

package ael_pkg;

  localparam int NAME_BYTES_DEF = 60;
  localparam logic [31:0] HEADER_MAGIC = 32'h4D43504B;
  localparam logic [31:0] HEADER_VERSION = 32'd1;
  localparam int HEADER_BYTES = 16;

  typedef enum logic [2:0] {
    ST_FOUND       = 3'd0,
    ST_TRUNCATED   = 3'd1,
    ST_BAD_MAGIC   = 3'd2,
    ST_BAD_VERSION = 3'd3,
    ST_NOT_FOUND   = 3'd4
  } status_t;

  typedef struct packed {
    logic       mode;
    logic [7:0] data;
    logic       first;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [63:0] data_offset;
    logic [63:0] data_size;
  } out_item_t;

endpackage

`default_nettype wire

// File: sv/ael_chan_if.sv
`default_nettype none

interface ael_chan_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: sv/ael_ram.sv
`default_nettype none

module ael_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 60,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [AW-1:0]        waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [AW-1:0]        raddr,
  output logic      [WIDTH-1:0]     rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

`default_nettype wire

// File: sv/ael_outq.sv
`default_nettype none

// Two-deep result queue: output register plus one skid slot.
module ael_outq (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire ael_pkg::out_item_t push_item,
  output logic                   full,
  ael_chan_if.source             result
);
  logic                o_valid;
  ael_pkg::out_item_t  o_item;
  logic                s_valid;
  ael_pkg::out_item_t  s_item;
  logic                pop;

  assign pop            = o_valid && result.ready;
  assign full           = s_valid;
  assign result.valid   = o_valid;
  assign result.payload = o_item;

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
      s_valid <= 1'b0;
    end else begin
      if (!o_valid || pop) begin
        if (s_valid) begin
          o_valid <= 1'b1;
          o_item  <= s_item;
          s_valid <= push;
          s_item  <= push_item;
        end else begin
          o_valid <= push;
          o_item  <= push_item;
        end
      end else if (push) begin
        s_valid <= 1'b1;
        s_item  <= push_item;
      end
    end
  end
endmodule

`default_nettype wire

// File: sv/archive_entry_lookup.sv
`default_nettype none

// Channel  Dir  Beat payload                         Handshake
// cfg      in   image_length, 64 bits                valid/ready, ready always high
// item     in   mode, data[7:0], first               valid/ready
// result   out  status[2:0], data_offset, data_size  valid/ready
//
// One item per cycle while a result slot is free; a result is registered in the
// result queue the cycle after the image byte that finishes the search. The name
// compare reads the name RAM at the byte's accept edge; the compare stage resolves
// it the cycle after. Synchronous reset clears all control state; the name RAM is
// not cleared. item.ready drops only while both result slots are full.
module archive_entry_lookup #(
  parameter int NAME_BYTES = ael_pkg::NAME_BYTES_DEF
) (
  input wire logic clk,
  input wire logic rst,
  ael_chan_if.sink   cfg,
  ael_chan_if.sink   item,
  ael_chan_if.source result
);
  localparam int AW          = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
  localparam int PW          = $clog2(NAME_BYTES + 16);
  localparam int FW          = $clog2(NAME_BYTES + 1);
  localparam int ENTRY_BYTES = NAME_BYTES + 16;

  localparam logic [PW-1:0] POS_LAST_NAME = PW'(NAME_BYTES - 1);
  localparam logic [PW-1:0] POS_NAME_END  = PW'(NAME_BYTES);
  localparam logic [PW-1:0] POS_OFF_END   = PW'(NAME_BYTES + 7);
  localparam logic [PW-1:0] POS_ENTRY_END = PW'(NAME_BYTES + 15);

  typedef enum logic [1:0] {
    CMP_ACTIVE = 2'd0,
    CMP_HIT    = 2'd1,
    CMP_MISS   = 2'd2
  } cmp_t;

  // state
  logic [63:0]   image_length;
  logic [63:0]   lim16;
  logic [FW-1:0] fill;
  logic [PW-1:0] pos;
  logic          in_header;
  logic [31:0]   entries_left;
  logic [63:0]   word;
  logic [63:0]   off_val;
  logic          off_bad;
  logic [63:0]   room;
  cmp_t          cmp_state;
  logic          search_done;
  logic          cmp_pend;
  logic [7:0]    cmp_byte;
  logic          cmp_last;

  logic [FW-1:0] fill_next;
  logic [PW-1:0] pos_next;
  logic          in_header_next;
  logic [31:0]   entries_left_next;
  logic [63:0]   word_next;
  logic [63:0]   off_val_next;
  logic          off_bad_next;
  logic [63:0]   room_next;
  cmp_t          cmp_state_next;
  logic          search_done_next;

  logic               q_full;
  logic               acc;
  logic               name_acc;
  logic               img_acc;
  logic               push;
  ael_pkg::out_item_t res;

  logic [FW-1:0] widx;
  logic          ram_we;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata;
  logic          cmp_issue;

  logic [PW-1:0] p;
  logic          e_done;
  logic          e_hdr;
  logic [31:0]   e_left;
  logic [31:0]   left_dec;
  logic [PW-1:0] body_k;
  logic [2:0]    kb;
  logic [63:0]   gw;
  logic [40:0]   prod;
  logic [64:0]   off_diff;

  assign cfg.ready  = 1'b1;
  assign item.ready = !q_full;
  assign acc        = item.valid && item.ready;
  assign name_acc   = acc && !item.payload.mode;
  assign img_acc    = acc && item.payload.mode;

  // name loading
  assign widx      = item.payload.first ? '0 : fill;
  assign ram_we    = name_acc && (widx < FW'(NAME_BYTES));
  assign fill_next = ram_we ? widx + 1'b1 : (name_acc ? widx : fill);

  assign p      = item.payload.first ? '0 : pos;
  assign e_done = item.payload.first ? 1'b0 : search_done;
  assign e_hdr  = item.payload.first ? 1'b1 : in_header;
  assign e_left = item.payload.first ? '0 : entries_left;
  assign raddr  = (p < POS_NAME_END) ? p[AW-1:0] : '0;

  // byte lane for field assembly
  assign body_k = p - POS_NAME_END;
  assign kb     = e_hdr ? {1'b0, p[1:0]} : body_k[2:0];
  assign gw     = (kb == 3'd0) ? {56'd0, item.payload.data}
                               : (word | ({56'd0, item.payload.data} << {kb, 3'b000}));
  assign prod     = 41'(gw[31:0]) * 41'(ENTRY_BYTES);
  assign off_diff = {1'b0, image_length} - {1'b0, gw};
  assign left_dec = (e_left != '0) ? e_left - 1'b1 : '0;

  ael_ram #(
    .WIDTH(8),
    .DEPTH(NAME_BYTES)
  ) u_name_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(widx[AW-1:0]),
    .wdata(item.payload.data),
    .re   (img_acc),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_comb begin
    pos_next          = pos;
    in_header_next    = in_header;
    entries_left_next = entries_left;
    word_next         = word;
    off_val_next      = off_val;
    off_bad_next      = off_bad;
    room_next         = room;
    cmp_state_next    = cmp_state;
    search_done_next  = search_done;
    cmp_issue         = 1'b0;
    push              = 1'b0;
    res               = '0;

    // compare stage: name RAM data is back
    if (cmp_pend && cmp_state == CMP_ACTIVE) begin
      if (cmp_byte != rdata) begin
        cmp_state_next = CMP_MISS;
      end else if (cmp_byte == 8'd0 || cmp_last) begin
        cmp_state_next = CMP_HIT;
      end
    end

    if (img_acc) begin
      if (item.payload.first) begin
        search_done_next  = 1'b0;
        in_header_next    = 1'b1;
        pos_next          = '0;
        cmp_state_next    = CMP_ACTIVE;
        entries_left_next = '0;
        word_next         = '0;
        off_val_next      = '0;
      end
      if (item.payload.first && image_length < 64'(ael_pkg::HEADER_BYTES)) begin
        push             = 1'b1;
        res.status       = ael_pkg::ST_TRUNCATED;
        search_done_next = 1'b1;
      end else if (!e_done) begin
        word_next = gw;
        if (e_hdr) begin
          if (p == PW'(3) && gw[31:0] != ael_pkg::HEADER_MAGIC) begin
            push             = 1'b1;
            res.status       = ael_pkg::ST_BAD_MAGIC;
            search_done_next = 1'b1;
          end else if (p == PW'(7) && gw[31:0] != ael_pkg::HEADER_VERSION) begin
            push             = 1'b1;
            res.status       = ael_pkg::ST_BAD_VERSION;
            search_done_next = 1'b1;
          end else if (p == PW'(11) && lim16 < 64'(prod)) begin
            push             = 1'b1;
            res.status       = ael_pkg::ST_TRUNCATED;
            search_done_next = 1'b1;
          end else if (p == PW'(11) && gw[31:0] == '0) begin
            push             = 1'b1;
            res.status       = ael_pkg::ST_NOT_FOUND;
            search_done_next = 1'b1;
          end else begin
            if (p == PW'(11)) begin
              entries_left_next = gw[31:0];
            end
            if (p >= PW'(15)) begin
              in_header_next = 1'b0;
              pos_next       = '0;
            end else begin
              pos_next = p + 1'b1;
            end
          end
        end else if (p < POS_NAME_END) begin
          word_next = word;
          cmp_issue = 1'b1;
          pos_next  = p + 1'b1;
        end else begin
          if (p == POS_OFF_END) begin
            off_val_next = gw;
            off_bad_next = off_diff[64];
            room_next    = off_diff[63:0];
          end
          if (p >= POS_ENTRY_END) begin
            if (cmp_state == CMP_HIT) begin
              push             = 1'b1;
              search_done_next = 1'b1;
              if (off_bad || gw > room) begin
                res.status = ael_pkg::ST_TRUNCATED;
              end else begin
                res.status      = ael_pkg::ST_FOUND;
                res.data_offset = off_val;
                res.data_size   = gw;
              end
            end else begin
              entries_left_next = left_dec;
              if (left_dec == '0) begin
                push             = 1'b1;
                res.status       = ael_pkg::ST_NOT_FOUND;
                search_done_next = 1'b1;
              end else begin
                cmp_state_next = CMP_ACTIVE;
                pos_next       = '0;
              end
            end
          end else begin
            pos_next = p + 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_length <= '0;
      fill         <= '0;
      pos          <= '0;
      in_header    <= 1'b1;
      entries_left <= '0;
      cmp_state    <= CMP_ACTIVE;
      search_done  <= 1'b1;
      cmp_pend     <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        image_length <= cfg.payload;
      end
      fill         <= fill_next;
      pos          <= pos_next;
      in_header    <= in_header_next;
      entries_left <= entries_left_next;
      cmp_state    <= cmp_state_next;
      search_done  <= search_done_next;
      cmp_pend     <= cmp_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cfg.valid && cfg.ready) begin
      lim16 <= cfg.payload - 64'(ael_pkg::HEADER_BYTES);
    end
    word     <= word_next;
    off_val  <= off_val_next;
    off_bad  <= off_bad_next;
    room     <= room_next;
    cmp_byte <= item.payload.data;
    cmp_last <= (p == POS_LAST_NAME);
  end

  ael_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_item(res),
    .full     (q_full),
    .result   (result)
  );
endmodule

`default_nettype wire
